/* rtl/pbrq_pkg.sv */
package pbrq_pkg;

  localparam int unsigned ThreadCountDef    = 64;
  localparam int unsigned PriorityLevelsDef = 256;
  localparam int unsigned BitmapWordBits    = 64;

  localparam int unsigned TidW = 6;
  localparam int unsigned PrioW = 8;

  typedef enum logic [1:0] {
    OpMakeReady = 2'd0,
    OpRemove    = 2'd1,
    OpChange    = 2'd2,
    OpQuery     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdDeq,
    StDeqLinks,
    StDeqFix,
    StEnqRd,
    StEnqWr,
    StScan,
    StHeadRd,
    StOut
  } state_e;

endpackage

/* rtl/priority_bitmap_ready_queue.sv */
// Each accepted input beat walks a sequence of dependent reads and writes on the head,
// tail and link memories, then a find-first-set scan over the bitmap one word at a time,
// before its result beat is registered.
// Throughput: one operation at a time; the next beat is taken once the result has left
// the output register.
// Reset: bitmap, queued flags, thread levels and idle_thread clear; the list memories
// hold undefined contents until written.
module priority_bitmap_ready_queue #(
  parameter int unsigned THREAD_COUNT     = pbrq_pkg::ThreadCountDef,
  parameter int unsigned PRIORITY_LEVELS  = pbrq_pkg::PriorityLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], thread_id[7:2], priority_req[15:8], thread_ready[16],
  // running_thread[22:17], running_priority[30:23], zero[31]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // best_thread[5:0], none_ready[6], best_level[14:7], switch_set[15],
  // switch_clear[16], zero[23:17]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned BITMAP_WORD_BITS = pbrq_pkg::BitmapWordBits;
  localparam int unsigned TidW  = pbrq_pkg::TidW;
  localparam int unsigned PrioW = pbrq_pkg::PrioW;
  localparam int unsigned WordCount =
    (PRIORITY_LEVELS + BITMAP_WORD_BITS - 1) / BITMAP_WORD_BITS;
  localparam int unsigned WordIdxW = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned BitIdxW  = $clog2(BITMAP_WORD_BITS);
  localparam int unsigned TIdxW    = $clog2(THREAD_COUNT);
  localparam int unsigned LIdxW    = $clog2(PRIORITY_LEVELS);

  pbrq_pkg::state_e state_q, state_d;

  logic [TidW-1:0] mem_head [PRIORITY_LEVELS];
  logic [TidW-1:0] mem_tail [PRIORITY_LEVELS];
  logic [TidW-1:0] mem_next [THREAD_COUNT];
  logic [TidW-1:0] mem_prev [THREAD_COUNT];
  logic [PrioW-1:0] mem_level [THREAD_COUNT];

  logic [BITMAP_WORD_BITS-1:0] bitmap_q [WordCount];
  logic [THREAD_COUNT-1:0]     queued_q;
  logic [THREAD_COUNT-1:0]     level_wr_q;
  logic [TidW-1:0]             idle_q;

  pbrq_pkg::op_e   op_q;
  logic [TIdxW-1:0] t_q;
  logic [TidW-1:0]  tfull_q;
  logic [PrioW-1:0] req_q, run_prio_q, lv_q;
  logic             ready_q, set_q, clr_q;
  logic [TidW-1:0]  run_q;
  logic [PrioW-1:0] level_rd_q;
  logic             level_hit_q;

  logic [TidW-1:0]  head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;
  logic [WordIdxW-1:0] scan_q;
  logic             found_q;
  logic [PrioW-1:0] best_lv_q;
  logic [23:0]      out_q;
  logic             out_valid_q;

  logic [1:0]       in_op;
  logic [7:0]       in_tid;
  logic [7:0]       in_req;
  logic [PrioW-1:0] req_sat;
  logic [PrioW-1:0] old_lv;
  logic [PrioW-1:0] lv_cur;

  assign in_op  = s_axis_tdata[1:0];
  assign in_tid = {2'b00, s_axis_tdata[7:2]};
  assign in_req = s_axis_tdata[15:8];
  assign req_sat = (32'(in_req) >= PRIORITY_LEVELS) ? PrioW'(PRIORITY_LEVELS - 1) : in_req;

  assign old_lv = level_hit_q ? level_rd_q : '0;
  assign lv_cur = (state_q == pbrq_pkg::StRdDeq) ? old_lv : lv_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == pbrq_pkg::StIdle) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  logic [LIdxW-1:0] lv_idx;
  logic [WordIdxW-1:0] lv_word;
  logic [BitIdxW-1:0]  lv_bit;
  logic             lv_occ;
  assign lv_idx  = LIdxW'(lv_cur);
  assign lv_word = WordIdxW'(lv_cur / PrioW'(BITMAP_WORD_BITS));
  assign lv_bit  = BitIdxW'(lv_cur % PrioW'(BITMAP_WORD_BITS));
  assign lv_occ  = bitmap_q[lv_word][lv_bit];

  logic is_head, is_tail;
  assign is_head = head_rd_q == tfull_q;
  assign is_tail = tail_rd_q == tfull_q;

  logic             ffs_hit;
  logic [BitIdxW-1:0] ffs_pos;
  always_comb begin
    ffs_hit = 1'b0;
    ffs_pos = '0;
    for (int b = BITMAP_WORD_BITS - 1; b >= 0; b--) begin
      if (bitmap_q[scan_q][b]) begin
        ffs_hit = 1'b1;
        ffs_pos = BitIdxW'(b);
      end
    end
  end

  logic mr_act;
  assign mr_act = ready_q && !queued_q[t_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbrq_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = pbrq_pkg::StRdDeq;
        end
      end
      pbrq_pkg::StRdDeq: begin
        case (op_q)
          pbrq_pkg::OpMakeReady: state_d = mr_act ? pbrq_pkg::StEnqRd : pbrq_pkg::StScan;
          pbrq_pkg::OpRemove:
            state_d = queued_q[t_q] ? pbrq_pkg::StDeqLinks : pbrq_pkg::StScan;
          pbrq_pkg::OpChange: begin
            if (old_lv == req_q) state_d = pbrq_pkg::StScan;
            else if (queued_q[t_q]) state_d = pbrq_pkg::StDeqLinks;
            else state_d = pbrq_pkg::StEnqRd;
          end
          default: state_d = pbrq_pkg::StScan;
        endcase
      end
      pbrq_pkg::StDeqLinks: state_d = pbrq_pkg::StDeqFix;
      pbrq_pkg::StDeqFix:
        state_d = (op_q == pbrq_pkg::OpChange) ? pbrq_pkg::StEnqRd : pbrq_pkg::StScan;
      pbrq_pkg::StEnqRd: state_d = mr_act ? pbrq_pkg::StEnqWr : pbrq_pkg::StScan;
      pbrq_pkg::StEnqWr: state_d = pbrq_pkg::StScan;
      pbrq_pkg::StScan: begin
        if (ffs_hit || 32'(scan_q) == WordCount - 1) state_d = pbrq_pkg::StHeadRd;
      end
      pbrq_pkg::StHeadRd: state_d = pbrq_pkg::StOut;
      pbrq_pkg::StOut: state_d = pbrq_pkg::StIdle;
      default: state_d = pbrq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbrq_pkg::StIdle;
      idle_q      <= '0;
      queued_q    <= '0;
      level_wr_q  <= '0;
      out_valid_q <= 1'b0;
      for (int w = 0; w < WordCount; w++) bitmap_q[w] <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) idle_q <= cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        pbrq_pkg::StIdle: begin
          scan_q  <= '0;
          found_q <= 1'b0;
        end
        pbrq_pkg::StDeqLinks: begin
          queued_q[t_q] <= 1'b0;
          if (is_head && is_tail) bitmap_q[lv_word][lv_bit] <= 1'b0;
        end
        pbrq_pkg::StEnqRd: begin
          if ((op_q == pbrq_pkg::OpMakeReady && mr_act) || op_q == pbrq_pkg::OpChange)
            level_wr_q[t_q] <= 1'b1;
        end
        pbrq_pkg::StEnqWr: begin
          queued_q[t_q] <= 1'b1;
          if (!lv_occ) bitmap_q[lv_word][lv_bit] <= 1'b1;
        end
        pbrq_pkg::StScan: begin
          if (ffs_hit) begin
            found_q <= 1'b1;
          end else if (32'(scan_q) != WordCount - 1) begin
            scan_q <= scan_q + 1'b1;
          end
        end
        pbrq_pkg::StOut: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  logic dq_set, ch_set, ch_clr;
  assign dq_set = tfull_q == run_q;
  assign ch_set = (tfull_q != run_q) && (req_q < run_prio_q);
  assign ch_clr = (tfull_q == run_q) && (old_lv > req_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      pbrq_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          op_q       <= (32'(in_tid) >= THREAD_COUNT) ? pbrq_pkg::OpQuery
                                                      : pbrq_pkg::op_e'(in_op);
          t_q        <= TIdxW'(in_tid);
          tfull_q    <= s_axis_tdata[7:2];
          req_q      <= req_sat;
          ready_q    <= s_axis_tdata[16];
          run_q      <= s_axis_tdata[22:17];
          run_prio_q <= s_axis_tdata[30:23];
          level_rd_q <= mem_level[TIdxW'(in_tid)];
          level_hit_q <= level_wr_q[TIdxW'(in_tid)];
          set_q      <= 1'b0;
          clr_q      <= 1'b0;
        end
      end
      pbrq_pkg::StRdDeq: begin
        head_rd_q <= mem_head[lv_idx];
        tail_rd_q <= mem_tail[lv_idx];
        next_rd_q <= mem_next[t_q];
        prev_rd_q <= mem_prev[t_q];
        lv_q <= (op_q == pbrq_pkg::OpMakeReady) ? req_q : old_lv;
        if (op_q == pbrq_pkg::OpMakeReady && mr_act)
          set_q <= ch_set;
        if (op_q == pbrq_pkg::OpRemove && queued_q[t_q]) set_q <= dq_set;
        if (op_q == pbrq_pkg::OpChange && old_lv != req_q) begin
          if (ch_clr) clr_q <= 1'b1;
          else set_q <= (queued_q[t_q] && dq_set) || ch_set;
        end
      end
      pbrq_pkg::StDeqLinks: begin
        if (!(is_head && is_tail)) begin
          if (is_head) mem_head[lv_idx] <= next_rd_q;
          else mem_next[TIdxW'(prev_rd_q)] <= next_rd_q;
        end
      end
      pbrq_pkg::StDeqFix: begin
        if (!(is_head && is_tail)) begin
          if (is_tail) mem_tail[lv_idx] <= prev_rd_q;
          else mem_prev[TIdxW'(next_rd_q)] <= prev_rd_q;
        end
        lv_q <= req_q;
      end
      pbrq_pkg::StEnqRd: begin
        lv_q      <= req_q;
        tail_rd_q <= mem_tail[LIdxW'(req_q)];
        if ((op_q == pbrq_pkg::OpMakeReady && mr_act) || op_q == pbrq_pkg::OpChange)
          mem_level[t_q] <= req_q;
      end
      pbrq_pkg::StEnqWr: begin
        if (!lv_occ) begin
          mem_head[lv_idx] <= tfull_q;
        end else begin
          mem_next[TIdxW'(tail_rd_q)] <= tfull_q;
          mem_prev[t_q] <= tail_rd_q;
        end
        mem_tail[lv_idx] <= tfull_q;
      end
      pbrq_pkg::StScan: begin
        best_lv_q <= PrioW'({scan_q, ffs_pos});
      end
      pbrq_pkg::StHeadRd: begin
        head_rd_q <= mem_head[LIdxW'(best_lv_q)];
      end
      pbrq_pkg::StOut: begin
        out_q <= found_q
          ? {7'd0, clr_q, set_q, best_lv_q, 1'b0, head_rd_q}
          : {7'd0, clr_q, set_q, 8'd0, 1'b1, idle_q};
      end
      default: ;
    endcase
  end

endmodule

/* tb/tb_priority_bitmap_ready_queue.sv */
module tb_priority_bitmap_ready_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NThreads = 64;
  localparam int unsigned NLevels = 256;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic       switch_clear;
    logic       switch_set;
    logic [7:0] best_level;
    logic       none_ready;
    logic [5:0] best_thread;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  priority_bitmap_ready_queue dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Scheduler shadow state.
  logic [5:0]  idle_id;
  logic        level_busy [NLevels];
  logic [5:0]  fifo_head [NLevels];
  logic [5:0]  fifo_tail [NLevels];
  logic [5:0]  next_tid [NThreads];
  logic [5:0]  prev_tid [NThreads];
  logic [7:0]  tid_level [NThreads];
  logic        tid_queued [NThreads];

  sched_result_t pending_results[$];
  int  error_count = 0;
  int  quiet_cycles = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void shadow_reset();
    idle_id = '0;
    for (int i = 0; i < NLevels; i++) level_busy[i] = 1'b0;
    for (int i = 0; i < NThreads; i++) begin
      tid_level[i] = '0;
      tid_queued[i] = 1'b0;
    end
  endfunction

  function automatic void link_tail(input logic [5:0] t, input logic [7:0] lv);
    if (!level_busy[lv]) begin
      fifo_head[lv] = t;
      level_busy[lv] = 1'b1;
    end else begin
      next_tid[fifo_tail[lv]] = t;
      prev_tid[t] = fifo_tail[lv];
    end
    fifo_tail[lv] = t;
    tid_queued[t] = 1'b1;
  endfunction

  function automatic void unlink(input logic [5:0] t);
    logic [7:0] lv;
    logic hd, tl;
    lv = tid_level[t];
    hd = fifo_head[lv] == t;
    tl = fifo_tail[lv] == t;
    tid_queued[t] = 1'b0;
    if (hd && tl) begin
      level_busy[lv] = 1'b0;
    end else begin
      if (hd) fifo_head[lv] = next_tid[t];
      else next_tid[prev_tid[t]] = next_tid[t];
      if (tl) fifo_tail[lv] = prev_tid[t];
      else prev_tid[next_tid[t]] = prev_tid[t];
    end
  endfunction

  function automatic bit admit(input logic [5:0] t, input logic [7:0] lv, input logic rdy,
                               input logic [5:0] run, input logic [7:0] run_lv);
    if (!rdy || tid_queued[t]) return 1'b0;
    tid_level[t] = lv;
    link_tail(t, lv);
    return t != run && lv < run_lv;
  endfunction

  function automatic sched_result_t schedule(input pbrq_pkg::op_e op, input logic [5:0] t,
      input logic [7:0] lv, input logic rdy, input logic [5:0] run, input logic [7:0] run_lv);
    sched_result_t r;
    logic [7:0] old;
    bit set, clr;
    set = 1'b0;
    clr = 1'b0;
    case (op)
      pbrq_pkg::OpMakeReady: set = admit(t, lv, rdy, run, run_lv);
      pbrq_pkg::OpRemove: begin
        if (tid_queued[t]) begin
          unlink(t);
          set = t == run;
        end
      end
      pbrq_pkg::OpChange: begin
        old = tid_level[t];
        if (old != lv) begin
          if (tid_queued[t]) begin
            unlink(t);
            if (t == run) set = 1'b1;
          end
          tid_level[t] = lv;
          if (admit(t, lv, rdy, run, run_lv)) set = 1'b1;
          if (t != run && lv < run_lv) set = 1'b1;
          if (t == run && old > lv) begin
            clr = 1'b1;
            set = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r = '0;
    r.none_ready = 1'b1;
    r.best_thread = idle_id;
    for (int i = NLevels - 1; i >= 0; i--) begin
      if (level_busy[i]) begin
        r.none_ready = 1'b0;
        r.best_level = i[7:0];
        r.best_thread = fifo_head[i];
      end
    end
    r.switch_set = set;
    r.switch_clear = clr;
    return r;
  endfunction

  task automatic idle_burst(input bit enable);
    if (enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic send_op(input pbrq_pkg::op_e op, input logic [5:0] t, input logic [7:0] lv,
                         input logic rdy, input logic [5:0] run, input logic [7:0] run_lv);
    idle_burst(idle_in);
    s_axis_tdata <= {1'b0, run_lv, run, rdy, lv, t, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(schedule(op, t, lv, rdy, run, run_lv));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_idle(input logic [5:0] v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    idle_id = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (idle_out && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[16:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.best_thread !== want.best_thread)
          report_mismatch($sformatf("best_thread %0d, want %0d", got.best_thread,
                                    want.best_thread));
        if (got.none_ready !== want.none_ready)
          report_mismatch($sformatf("none_ready %0b, want %0b", got.none_ready,
                                    want.none_ready));
        if (got.best_level !== want.best_level)
          report_mismatch($sformatf("best_level %0d, want %0d", got.best_level,
                                    want.best_level));
        if (got.switch_set !== want.switch_set)
          report_mismatch($sformatf("switch_set %0b, want %0b", got.switch_set,
                                    want.switch_set));
        if (got.switch_clear !== want.switch_clear)
          report_mismatch($sformatf("switch_clear %0b, want %0b", got.switch_clear,
                                    want.switch_clear));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !(s_axis_tvalid || cfg_valid_i ||
        pending_results.size() != 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(pbrq_pkg::OpQuery, 6'd0, 8'd0, 1'b0, 6'd0, 8'd0);
    send_op(pbrq_pkg::OpMakeReady, 6'd63, 8'd255, 1'b1, 6'd0, 8'd255);
    send_op(pbrq_pkg::OpMakeReady, 6'd5, 8'd10, 1'b1, 6'd1, 8'd20);
    send_op(pbrq_pkg::OpMakeReady, 6'd6, 8'd10, 1'b1, 6'd6, 8'd20);
    send_op(pbrq_pkg::OpMakeReady, 6'd7, 8'd10, 1'b1, 6'd1, 8'd20);
    send_op(pbrq_pkg::OpMakeReady, 6'd5, 8'd0, 1'b1, 6'd1, 8'd20);
    send_op(pbrq_pkg::OpMakeReady, 6'd8, 8'd0, 1'b0, 6'd1, 8'd20);
    send_op(pbrq_pkg::OpMakeReady, 6'd0, 8'd0, 1'b1, 6'd1, 8'd0);
    send_op(pbrq_pkg::OpRemove, 6'd6, 8'd0, 1'b0, 6'd1, 8'd0);
    send_op(pbrq_pkg::OpRemove, 6'd0, 8'd0, 1'b0, 6'd0, 8'd0);
    send_op(pbrq_pkg::OpRemove, 6'd0, 8'd0, 1'b0, 6'd0, 8'd0);
    send_op(pbrq_pkg::OpChange, 6'd5, 8'd10, 1'b1, 6'd1, 8'd20);
    send_op(pbrq_pkg::OpChange, 6'd5, 8'd3, 1'b1, 6'd5, 8'd10);
    send_op(pbrq_pkg::OpChange, 6'd7, 8'd200, 1'b0, 6'd7, 8'd10);
    send_op(pbrq_pkg::OpChange, 6'd9, 8'd1, 1'b0, 6'd2, 8'd50);
    send_op(pbrq_pkg::OpChange, 6'd63, 8'd64, 1'b1, 6'd63, 8'd255);
    send_op(pbrq_pkg::OpQuery, 6'd63, 8'd255, 1'b1, 6'd63, 8'd255);
    send_op(pbrq_pkg::OpRemove, 6'd5, 8'd0, 1'b0, 6'd5, 8'd0);
    send_op(pbrq_pkg::OpRemove, 6'd63, 8'd0, 1'b0, 6'd0, 8'd0);
    send_op(pbrq_pkg::OpRemove, 6'd9, 8'd0, 1'b0, 6'd0, 8'd0);
    send_op(pbrq_pkg::OpQuery, 6'd0, 8'd0, 1'b0, 6'd0, 8'd0);
  endtask

  task automatic test_random(input int count, input int level_span);
    pbrq_pkg::op_e op;
    int  pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      op = pick < 4 ? pbrq_pkg::OpMakeReady : pick < 7 ? pbrq_pkg::OpRemove :
           pick < 9 ? pbrq_pkg::OpChange : pbrq_pkg::OpQuery;
      send_op(op, 6'($urandom_range(0, 63)), 8'($urandom_range(0, level_span)),
              1'($urandom_range(0, 5) != 0), 6'($urandom_range(0, 63)),
              8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    shadow_reset();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_idle(6'd63);
    test_random(250, 7);
    write_idle(6'd21);
    test_random(250, 255);
    write_idle(6'd0);
    idle_in = 1'b0;
    idle_out = 1'b0;
    test_random(250, 3);
    drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
